[sv/assert_macros.svh]
// Assertion helpers for the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising clk edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/hhb_pkg.sv]
package hhb_pkg;

  localparam int HUE_BIN_COUNT = 180;
  localparam int COUNT_BITS    = 20;
  localparam int QUEUE_DEPTH   = 2;
  localparam int REG_BITS      = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam logic [7:0] MIN_SAT_VAL = 8'd30;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_TRAIN  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEFT   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TOP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_HEIGHT = 3'd5;

  typedef struct packed {
    logic [REG_BITS-1:0] frame_width;
    logic [REG_BITS-1:0] frame_height;
    logic [REG_BITS-1:0] window_left;
    logic [REG_BITS-1:0] window_top;
    logic [REG_BITS-1:0] window_width;
    logic [REG_BITS-1:0] window_height;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic       qual;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef enum logic [1:0] {F_IDLE, F_PREP, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_READ, B_WDIV, B_OUT} back_state_t;

endpackage

[sv/hhb_ram.sv]
module hhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/hhb_div.sv]
module hhb_div #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW+QW-1:0] numer,
  input  logic [DW-1:0]    denom,
  output logic             done,
  output logic [QW-1:0]    quot
);

  localparam int CW = $clog2(QW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   sub;
  logic          ge;

  // One restoring step per cycle
  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign sub   = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift quotient bits in as the dividend bits move out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer[DW+QW-1:QW];
      low_r <= numer[QW-1:0];
      den_r <= denom;
    end else if (busy_r) begin
      rem_r <= ge ? sub[DW-1:0] : trial[DW-1:0];
      low_r <= {low_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

[sv/hhb_front.sv]
module hhb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hhb_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_kind,
  input  logic [11:0]           in_pixel_x,
  input  logic [11:0]           in_pixel_y,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  hhb_pkg::qstat_t       qstat,
  output logic                  push,
  output hhb_pkg::item_t        push_item
);

  hhb_pkg::front_state_t state_r, state_nxt;

  logic [1:0]  kind_r;
  logic [11:0] px_r, py_r;
  logic [7:0]  r_r, g_r, b_r;
  logic        win_r, dz_r, mz_r;
  hhb_pkg::item_t item_r;

  logic [7:0]  mx, mn, diff;
  logic [15:0] d16, hnum, snum;
  logic [12:0] xe, ye;
  logic        win;
  logic        start;
  logic        hdone, sdone;
  logic [7:0]  hq, sq;
  logic [7:0]  hue_v, sat_v;

  // Max, min, hue and saturation numerators from the held pixel
  always_comb begin
    mx = r_r;
    mn = r_r;
    if (g_r > mx) mx = g_r;
    if (b_r > mx) mx = b_r;
    if (g_r < mn) mn = g_r;
    if (b_r < mn) mn = b_r;
    diff = mx - mn;
    d16  = {8'd0, diff};
    if (mx == r_r) begin
      if (g_r >= b_r) hnum = 16'd30 * {8'd0, g_r - b_r};
      else            hnum = 16'd180 * d16 - 16'd30 * {8'd0, b_r - g_r};
    end else if (mx == g_r) begin
      if (b_r >= r_r) hnum = 16'd60 * d16 + 16'd30 * {8'd0, b_r - r_r};
      else            hnum = 16'd60 * d16 - 16'd30 * {8'd0, r_r - b_r};
    end else begin
      if (r_r >= g_r) hnum = 16'd120 * d16 + 16'd30 * {8'd0, r_r - g_r};
      else            hnum = 16'd120 * d16 - 16'd30 * {8'd0, g_r - r_r};
    end
    snum = {diff, 8'd0} - d16;
  end

  // Window test, sums kept one bit wider
  assign xe  = {1'b0, cfg.window_left} + {1'b0, cfg.window_width};
  assign ye  = {1'b0, cfg.window_top} + {1'b0, cfg.window_height};
  assign win = (px_r < cfg.frame_width) && (py_r < cfg.frame_height) &&
               (px_r >= cfg.window_left) && ({1'b0, px_r} < xe) &&
               (py_r >= cfg.window_top) && ({1'b0, py_r} < ye);

  hhb_div #(.DW(8), .QW(8)) u_hue_div (
    .clk(clk), .rst_n(rst_n), .start(start), .numer(hnum), .denom(diff),
    .done(hdone), .quot(hq)
  );

  hhb_div #(.DW(8), .QW(8)) u_sat_div (
    .clk(clk), .rst_n(rst_n), .start(start), .numer(snum), .denom(mx),
    .done(sdone), .quot(sq)
  );

  assign hue_v = dz_r ? 8'd0 : hq;
  assign sat_v = mz_r ? 8'd0 : sq;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hhb_pkg::F_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    start     = 1'b0;
    push      = 1'b0;
    case (state_r)
      hhb_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = hhb_pkg::F_PREP;
      end
      hhb_pkg::F_PREP: begin
        start     = 1'b1;
        state_nxt = hhb_pkg::F_DIV;
      end
      hhb_pkg::F_DIV: begin
        if (hdone && sdone) state_nxt = hhb_pkg::F_PUSH;
      end
      hhb_pkg::F_PUSH: begin
        push = !qstat.full;
        if (!qstat.full) state_nxt = hhb_pkg::F_IDLE;
      end
      default: state_nxt = hhb_pkg::F_IDLE;
    endcase
  end

  // Hold the item through classification
  always_ff @(posedge clk) begin
    if (state_r == hhb_pkg::F_IDLE && in_valid) begin
      kind_r <= in_kind;
      px_r   <= in_pixel_x;
      py_r   <= in_pixel_y;
      r_r    <= in_red;
      g_r    <= in_green;
      b_r    <= in_blue;
    end
    if (state_r == hhb_pkg::F_PREP) begin
      win_r <= win;
      dz_r  <= (diff == 8'd0);
      mz_r  <= (mx == 8'd0);
      item_r.val <= mx;
    end
    if (state_r == hhb_pkg::F_DIV && hdone) begin
      item_r.kind <= kind_r;
      item_r.hue  <= hue_v;
      item_r.sat  <= sat_v;
      item_r.qual <= win_r && (sat_v >= hhb_pkg::MIN_SAT_VAL) &&
                     (item_r.val >= hhb_pkg::MIN_SAT_VAL);
    end
  end

  assign push_item = item_r;

endmodule

[sv/hhb_queue.sv]
module hhb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hhb_pkg::item_t  push_item,
  input  logic            pop,
  output hhb_pkg::item_t  head,
  output hhb_pkg::qstat_t qstat
);

  localparam int PW = (hhb_pkg::QUEUE_DEPTH > 1) ? $clog2(hhb_pkg::QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(hhb_pkg::QUEUE_DEPTH + 1);

  hhb_pkg::item_t entry_r [hhb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [NW-1:0] cnt_r;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(hhb_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(hhb_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (push && !pop)      cnt_r <= cnt_r + NW'(1);
      else if (pop && !push) cnt_r <= cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wptr_r] <= push_item;
  end

  assign head        = entry_r[rptr_r];
  assign qstat.full  = (cnt_r == NW'(hhb_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt_r == '0);

endmodule

[sv/hhb_back.sv]
module hhb_back #(
  parameter int HUE_BIN_COUNT = hhb_pkg::HUE_BIN_COUNT,
  parameter int COUNT_BITS    = hhb_pkg::COUNT_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  hhb_pkg::item_t  head,
  input  hhb_pkg::qstat_t qstat,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_weight,
  output logic [7:0]      out_hue,
  output logic [7:0]      out_saturation,
  output logic [7:0]      out_brightness,
  output logic            out_counted,
  output logic            out_histogram_empty
);

  localparam int HW = $clog2(HUE_BIN_COUNT);

  hhb_pkg::back_state_t state_r, state_nxt;

  logic [HUE_BIN_COUNT-1:0] vld_r;
  logic [COUNT_BITS-1:0]    peak_r;
  hhb_pkg::item_t           item_r;
  logic                     bin_vld_r;
  logic [15:0]              weight_r;
  logic                     counted_r;

  logic [COUNT_BITS-1:0]    rdata, count, inc;
  logic                     we;
  logic                     wdiv_start, wdiv_done;
  logic [COUNT_BITS+15:0]   wnum;
  logic [15:0]              wq;

  hhb_ram #(.WIDTH(COUNT_BITS), .DEPTH(HUE_BIN_COUNT)) u_bins (
    .clk(clk), .we(we), .waddr(item_r.hue[HW-1:0]), .wdata(inc),
    .raddr(head.hue[HW-1:0]), .rdata(rdata)
  );

  // A bin not written since the last clear reads as zero
  assign count = bin_vld_r ? rdata : '0;
  assign inc   = count + COUNT_BITS'(1);
  assign we    = (state_r == hhb_pkg::B_READ) && (item_r.kind == hhb_pkg::KIND_TRAIN) &&
                 item_r.qual && (count != '1);
  assign wnum  = {count, 16'd0} - {16'd0, count};

  hhb_div #(.DW(COUNT_BITS), .QW(16)) u_weight_div (
    .clk(clk), .rst_n(rst_n), .start(wdiv_start), .numer(wnum), .denom(peak_r),
    .done(wdiv_done), .quot(wq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hhb_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and handshake
  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    wdiv_start = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      hhb_pkg::B_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (head.kind == hhb_pkg::KIND_TRAIN || head.kind == hhb_pkg::KIND_LOOKUP) begin
            state_nxt = hhb_pkg::B_READ;
          end else begin
            state_nxt = hhb_pkg::B_OUT;
          end
        end
      end
      hhb_pkg::B_READ: begin
        if (item_r.kind == hhb_pkg::KIND_LOOKUP && peak_r != '0) begin
          wdiv_start = 1'b1;
          state_nxt  = hhb_pkg::B_WDIV;
        end else begin
          state_nxt = hhb_pkg::B_OUT;
        end
      end
      hhb_pkg::B_WDIV: begin
        if (wdiv_done) state_nxt = hhb_pkg::B_OUT;
      end
      hhb_pkg::B_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = hhb_pkg::B_IDLE;
      end
      default: state_nxt = hhb_pkg::B_IDLE;
    endcase
  end

  // Histogram control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      peak_r <= '0;
    end else begin
      if (pop && head.kind == hhb_pkg::KIND_CLEAR) begin
        vld_r  <= '0;
        peak_r <= '0;
      end
      if (we) begin
        vld_r[item_r.hue[HW-1:0]] <= 1'b1;
        if (inc > peak_r) peak_r <= inc;
      end
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r    <= head;
      bin_vld_r <= vld_r[head.hue[HW-1:0]];
      weight_r  <= 16'd0;
      counted_r <= 1'b0;
    end
    if (we) counted_r <= 1'b1;
    if (state_r == hhb_pkg::B_WDIV && wdiv_done) weight_r <= wq;
  end

  assign out_weight          = weight_r;
  assign out_hue             = item_r.hue;
  assign out_saturation      = item_r.sat;
  assign out_brightness      = item_r.val;
  assign out_counted         = counted_r;
  assign out_histogram_empty = (peak_r == '0);

endmodule

[sv/hue_histogram_backprojection_top.sv]
// Hue histogram and backprojection.
// Input channel in_*: one item per pixel, kind selects clear, train or lookup.
// Output channel out_*: exactly one result item per input item, in order.
// Configuration: cfg_we writes cfg_data (low 12 bits) to register cfg_index;
// write only while no item is in flight.
// The front takes a new item only once it has pushed the last one, as it waits
// for the 8-step hue and saturation dividers; a lookup holds the back for the
// 16-step weight divider, and the back takes no new item from the queue meanwhile.
// A 2-entry queue parts front and back, so the front keeps taking items while
// a result waits. When out_ready is low the result holds, the queue fills,
// then in_ready drops.
// Reset (rst_n low, synchronous) restores the register defaults, marks every
// hue bin empty and zeroes the peak; the block is ready on the next cycle.
`include "assert_macros.svh"

module hue_histogram_backprojection_top #(
  parameter int HUE_BIN_COUNT = hhb_pkg::HUE_BIN_COUNT,
  parameter int COUNT_BITS    = hhb_pkg::COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_weight,
  output logic [7:0]  out_hue,
  output logic [7:0]  out_saturation,
  output logic [7:0]  out_brightness,
  output logic        out_counted,
  output logic        out_histogram_empty
);

  hhb_pkg::cfg_t   cfg_r;
  hhb_pkg::qstat_t qstat;
  hhb_pkg::item_t  push_item, head;
  logic            push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width   <= 12'd640;
      cfg_r.frame_height  <= 12'd480;
      cfg_r.window_left   <= 12'd0;
      cfg_r.window_top    <= 12'd0;
      cfg_r.window_width  <= 12'd0;
      cfg_r.window_height <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        hhb_pkg::REG_FRAME_WIDTH:   cfg_r.frame_width   <= cfg_data;
        hhb_pkg::REG_FRAME_HEIGHT:  cfg_r.frame_height  <= cfg_data;
        hhb_pkg::REG_WINDOW_LEFT:   cfg_r.window_left   <= cfg_data;
        hhb_pkg::REG_WINDOW_TOP:    cfg_r.window_top    <= cfg_data;
        hhb_pkg::REG_WINDOW_WIDTH:  cfg_r.window_width  <= cfg_data;
        hhb_pkg::REG_WINDOW_HEIGHT: cfg_r.window_height <= cfg_data;
        default: ;
      endcase
    end
  end

  hhb_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .qstat(qstat), .push(push), .push_item(push_item)
  );

  hhb_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .qstat(qstat)
  );

  hhb_back #(.HUE_BIN_COUNT(HUE_BIN_COUNT), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .qstat(qstat), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_weight(out_weight),
    .out_hue(out_hue), .out_saturation(out_saturation),
    .out_brightness(out_brightness), .out_counted(out_counted),
    .out_histogram_empty(out_histogram_empty)
  );

  `ASSERT_CLK(a_counted_not_empty, (out_valid && out_counted) |-> !out_histogram_empty, "counted item left histogram empty")
  `ASSERT_CLK(a_counted_no_weight, (out_valid && out_counted) |-> (out_weight == 16'd0), "train item carries a weight")
  `ASSERT_CLK(a_hue_range, out_valid |-> (out_hue < 8'd180), "hue out of range")
  `ASSERT_CLK(a_no_push_full, push |-> !qstat.full, "push into full queue")

endmodule
